FILE: design/sce_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and lookup tables of the softmax cross-entropy unit
// no dependencies
package sce_pkg;

    localparam int MAX_CLASSES_DEF = 64;
    localparam int CLS_W   = 7;
    localparam int POS_W   = 32;
    localparam int LOGIT_W = 16;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 23;
    localparam int LOSS_W  = 48;
    localparam int E_W     = 17;
    localparam int NUM_W   = 49;
    localparam int DEN_W   = 40;
    localparam int IDX_W   = 8;
    localparam logic [18:0] LN2_Q16 = 19'd45426;

    localparam logic [IDX_W-1:0] REG_MODE  = 8'd0;
    localparam logic [IDX_W-1:0] REG_NCLS  = 8'd1;
    localparam logic [IDX_W-1:0] REG_NPOS  = 8'd2;
    localparam logic [IDX_W-1:0] REG_UGRAD = 8'd3;

    typedef enum logic [1:0] {
        KIND_GRAD = 2'd0,
        KIND_LOSS = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAX,
        S_EXP,
        S_LN1,
        S_LN2,
        S_GRD_RD,
        S_GRD_P,
        S_GRD_WP,
        S_GRD_MUL,
        S_GRD_Q,
        S_GRD_WQ,
        S_GRD_OUT,
        S_BEND,
        S_MEAN,
        S_MEAN_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        t_kind            kind;
        logic [VAL_W-1:0] value;
        logic [5:0]       cls;
        logic             last;
    } t_result;

    function automatic logic [16:0] exp_int(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_hi(input logic [3:0] h);
        logic [16:0] v;
        case (h)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57836;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_lo(input logic [3:0] f);
        logic [16:0] v;
        case (f)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65280;
            4'd2:    v = 17'd65026;
            4'd3:    v = 17'd64772;
            4'd4:    v = 17'd64520;
            4'd5:    v = 17'd64268;
            4'd6:    v = 17'd64018;
            4'd7:    v = 17'd63768;
            4'd8:    v = 17'd63520;
            4'd9:    v = 17'd63272;
            4'd10:   v = 17'd63025;
            4'd11:   v = 17'd62780;
            4'd12:   v = 17'd62535;
            4'd13:   v = 17'd62291;
            4'd14:   v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] ln_tab(input logic [4:0] j);
        logic [15:0] v;
        case (j)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3973;
            5'd2:    v = 16'd7719;
            5'd3:    v = 16'd11262;
            5'd4:    v = 16'd14624;
            5'd5:    v = 16'd17821;
            5'd6:    v = 16'd20870;
            5'd7:    v = 16'd23783;
            5'd8:    v = 16'd26573;
            5'd9:    v = 16'd29248;
            5'd10:   v = 16'd31818;
            5'd11:   v = 16'd34292;
            5'd12:   v = 16'd36675;
            5'd13:   v = 16'd38975;
            5'd14:   v = 16'd41196;
            5'd15:   v = 16'd43345;
            default: v = 16'd45426;
        endcase
        return v;
    endfunction

endpackage

FILE: design/sce_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: logit input, result output, register writes
// depends on nothing
interface sce_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] logit;
    logic signed [15:0] target_class;
    modport source (output valid, logit, target_class, input ready);
    modport sink (input valid, logit, target_class, output ready);
endinterface

interface sce_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic signed [31:0] value;
    logic [5:0]         class_index;
    logic               last;
    modport source (output valid, result_kind, value, class_index, last, input ready);
    modport sink (input valid, result_kind, value, class_index, last, output ready);
endinterface

interface sce_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/sce_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module sce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/sce_div.sv
`timescale 1ns / 1ps
// restoring unsigned divider, one quotient bit per cycle
// depends on sce_pkg
module sce_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sce_pkg::t_div_req i_req,
    output sce_pkg::t_div_rsp o_rsp
);
    localparam int NW    = sce_pkg::NUM_W;
    localparam int DW    = sce_pkg::DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DW:0]      r_rem, n_rem;
    logic [NW-1:0]    r_quo, n_quo;
    logic [DW-1:0]    r_den, n_den;
    logic [DW:0]      rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        rem_sh = {r_rem[DW-1:0], r_quo[NW-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.num;
            n_den  = i_req.den;
        end else if (r_busy) begin
            // shift in the next numerator bit, subtract when it fits
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = rem_sh - {1'b0, r_den};
                n_quo = {r_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

FILE: design/softmax_cross_entropy_unit.sv
`timescale 1ns / 1ps
// top level of the softmax cross-entropy loss and gradient unit
// depends on sce_pkg, sce_if, sce_ram, sce_div
//
// Takes one Q8.8 logit word per class, class 0 first; the class-0 word also
// carries the target class. Logits go into a logit ram as they arrive, at one
// word per cycle while idle and the output slot is free. On the last class of
// a vector the input stalls while the unit makes a max pass over the ram, then
// an exp pass that writes exp(logit-max) into a second ram and sums it. In
// forward mode a table log (states LN1, LN2) follows and the loss is added to
// the batch sum; after the final position the mean comes out of the shared
// serial divider. In backward mode each class takes two divisions (softmax,
// then scaling by 256*num_positions). A target out of range gives one error
// word and the rest of the batch gives no words. Errors, the mean and the
// last gradient of a vector carry last. Registers may be written only while
// the unit is idle.
module softmax_cross_entropy_unit #(
    parameter int MAX_CLASSES = sce_pkg::MAX_CLASSES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sce_in_if.sink    i_in,
    sce_out_if.source o_out,
    sce_cfg_if.sink   i_cfg
);
    localparam int AW = $clog2(MAX_CLASSES);
    localparam int CW = sce_pkg::CLS_W;
    localparam int PW = sce_pkg::POS_W;
    localparam int LW = sce_pkg::LOSS_W;
    localparam int SW = sce_pkg::SUM_W;
    localparam int EW = sce_pkg::E_W;
    localparam int NW = sce_pkg::NUM_W;
    localparam int DW = sce_pkg::DEN_W;
    localparam logic [CW-1:0] MAXC = CW'(MAX_CLASSES);

    // configuration registers
    logic               r_mode;
    logic [CW-1:0]      r_ncls;
    logic [PW-1:0]      r_npos;
    logic signed [15:0] r_ug;

    sce_pkg::t_state r_state, n_state;

    // vector and batch state
    logic [CW-1:0]      r_cc, n_cc;
    logic signed [15:0] r_held, n_held;
    logic [PW-1:0]      r_pos, n_pos;
    logic [LW-1:0]      r_loss, n_loss;
    logic               r_drop, n_drop;
    logic [CW-1:0]      r_cnt, n_cnt;

    // pass datapath
    logic [CW-1:0]      r_ra, n_ra;
    logic               r_rv;
    logic [CW-1:0]      r_ri;
    logic signed [15:0] r_mx, n_mx;
    logic signed [15:0] r_tl, n_tl;
    logic               r_av, r_bv;
    logic [CW-1:0]      r_ai, r_bi;
    logic [33:0]        r_am1, r_bm2;
    logic [3:0]         r_af;
    logic [SW-1:0]      r_sum, n_sum;
    logic [33:0]        r_lnp, n_lnp;
    logic [18:0]        r_lnb, n_lnb;
    logic [CW-1:0]      r_gc, n_gc;
    logic [NW-1:0]      r_q, n_q;
    logic signed [17:0] r_diff, n_diff;
    logic signed [33:0] r_prod, n_prod;

    // output word register
    logic              r_ov, n_ov;
    sce_pkg::t_result  r_res, n_res;

    // clamped registers
    logic [CW-1:0] ncls_c;
    logic [PW-1:0] npos_c;
    always_comb begin
        ncls_c = (r_ncls == '0) ? CW'(1) : ((r_ncls > MAXC) ? MAXC : r_ncls);
        npos_c = (r_npos == '0) ? PW'(1) : r_npos;
    end

    logic slot_free, in_acc, bend, issue;
    assign slot_free = !r_ov || o_out.ready;
    assign in_acc    = i_in.valid && i_in.ready;
    assign bend      = ({1'b0, r_pos} + 33'd1 >= {1'b0, npos_c}) || (r_pos == '1);
    assign issue     = (r_state == sce_pkg::S_MAX || r_state == sce_pkg::S_EXP)
                       && (r_ra < r_cnt);

    // input word checks
    logic               first, err0, err1, drop1, vend;
    logic signed [15:0] held_in;
    logic [CW-1:0]      cnt_in;
    always_comb begin
        first   = (r_cc == '0) && !r_drop;
        held_in = first ? i_in.target_class : r_held;
        err0    = first && (i_in.target_class < 16'sd0
                  || i_in.target_class >= $signed({9'b0, ncls_c}));
        drop1   = r_drop || err0;
        cnt_in  = r_cc + 1'b1;
        vend    = (cnt_in >= ncls_c) || (cnt_in >= MAXC);
        err1    = vend && !drop1 && (held_in < 16'sd0
                  || held_in >= $signed({9'b0, cnt_in}));
    end

    // memories and divider
    logic [15:0]       lg_rdata;
    logic [EW-1:0]     e_rdata, e_wdata;
    logic              e_we;
    sce_pkg::t_div_req div_req;
    sce_pkg::t_div_rsp div_rsp;

    sce_ram #(.WIDTH(16), .DEPTH(MAX_CLASSES)) u_logit_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_cc[AW-1:0]),
        .i_wdata (i_in.logit),
        .i_raddr (r_ra[AW-1:0]),
        .o_rdata (lg_rdata)
    );

    sce_ram #(.WIDTH(EW), .DEPTH(MAX_CLASSES)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_bi[AW-1:0]),
        .i_wdata (e_wdata),
        .i_raddr (r_gc[AW-1:0]),
        .o_rdata (e_rdata)
    );

    sce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // exp pipeline, stage a: table product of integer and high fraction
    logic signed [16:0] xs;
    logic [16:0]        xd;
    logic [33:0]        am1;
    always_comb begin
        xs  = $signed({r_mx[15], r_mx}) - $signed({lg_rdata[15], lg_rdata});
        xd  = xs;
        am1 = (xd[16:12] != 5'd0) ? 34'd0
              : sce_pkg::exp_int(xd[11:8]) * sce_pkg::exp_hi(xd[7:4]);
    end

    // stage b rounds and applies the low fraction, stage c rounds and writes
    logic [34:0] am1_rnd, bm2_rnd;
    logic [33:0] bm2;
    always_comb begin
        am1_rnd = {1'b0, r_am1} + 35'd32768;
        bm2     = am1_rnd[32:16] * sce_pkg::exp_lo(r_af);
        bm2_rnd = {1'b0, r_bm2} + 35'd32768;
        e_wdata = bm2_rnd[32:16];
        e_we    = r_bv;
    end

    // table log of the exp sum, sum is at least one in q16
    logic [2:0]  pp;
    logic [22:0] t_norm;
    logic [15:0] ln_lo, ln_hi;
    always_comb begin
        pp = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (r_sum[16 + i]) begin
                pp = 3'(i);
            end
        end
        t_norm = r_sum << (3'd6 - pp);
        ln_lo  = sce_pkg::ln_tab({1'b0, t_norm[21:18]});
        ln_hi  = sce_pkg::ln_tab({1'b0, t_norm[21:18]} + 5'd1);
        n_lnp  = 34'(ln_hi - ln_lo) * 34'(t_norm[17:0]);
        n_lnb  = 19'(pp) * sce_pkg::LN2_Q16 + 19'(ln_lo);
    end

    logic [34:0] lnp_rnd;
    logic [19:0] ln_val;
    logic [16:0] marg;
    logic [25:0] pl;
    logic [LW:0] lsum;
    always_comb begin
        lnp_rnd = {1'b0, r_lnp} + 35'd131072;
        ln_val  = {1'b0, r_lnb} + 20'(lnp_rnd[34:18]);
        marg    = 17'($signed({r_mx[15], r_mx}) - $signed({r_tl[15], r_tl}));
        pl      = {1'b0, marg, 8'b0} + 26'(ln_val);
        lsum    = {1'b0, r_loss} + (LW + 1)'(pl);
    end

    // gradient helpers
    logic        hit;
    logic [33:0] mag;
    logic        neg;
    assign hit = ($signed({9'b0, r_gc}) == r_held);
    assign neg = r_prod < 0;
    assign mag = neg ? 34'(-r_prod) : 34'(r_prod);

    // divider requests
    always_comb begin
        div_req = '0;
        case (r_state)
            sce_pkg::S_GRD_P: begin
                div_req.start = 1'b1;
                div_req.num   = NW'({e_rdata, 16'b0}) + NW'(r_sum[SW-1:1]);
                div_req.den   = DW'(r_sum);
            end
            sce_pkg::S_GRD_Q: begin
                div_req.start = 1'b1;
                div_req.num   = NW'(mag) + NW'({npos_c, 7'b0});
                div_req.den   = {npos_c, 8'b0};
            end
            sce_pkg::S_BEND: begin
                div_req.start = bend && !r_mode && !r_drop;
                div_req.num   = NW'(r_loss) + NW'(npos_c[PW-1:1]);
                div_req.den   = DW'(npos_c);
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sce_pkg::S_IDLE: begin
                if (in_acc && vend && !(drop1 || err1)) begin
                    n_state = sce_pkg::S_MAX;
                end
            end
            sce_pkg::S_MAX: begin
                if (r_rv && r_ri == r_cnt - 1'b1) begin
                    n_state = sce_pkg::S_EXP;
                end
            end
            sce_pkg::S_EXP: begin
                if (r_bv && r_bi == r_cnt - 1'b1) begin
                    n_state = r_mode ? sce_pkg::S_GRD_RD : sce_pkg::S_LN1;
                end
            end
            sce_pkg::S_LN1:     n_state = sce_pkg::S_LN2;
            sce_pkg::S_LN2:     n_state = sce_pkg::S_BEND;
            sce_pkg::S_GRD_RD:  n_state = sce_pkg::S_GRD_P;
            sce_pkg::S_GRD_P:   n_state = sce_pkg::S_GRD_WP;
            sce_pkg::S_GRD_WP: begin
                if (div_rsp.done) begin
                    n_state = sce_pkg::S_GRD_MUL;
                end
            end
            sce_pkg::S_GRD_MUL: n_state = sce_pkg::S_GRD_Q;
            sce_pkg::S_GRD_Q:   n_state = sce_pkg::S_GRD_WQ;
            sce_pkg::S_GRD_WQ: begin
                if (div_rsp.done) begin
                    n_state = sce_pkg::S_GRD_OUT;
                end
            end
            sce_pkg::S_GRD_OUT: begin
                if (slot_free) begin
                    n_state = (r_gc == r_cnt - 1'b1) ? sce_pkg::S_BEND
                                                     : sce_pkg::S_GRD_RD;
                end
            end
            sce_pkg::S_BEND: begin
                n_state = (bend && !r_mode && !r_drop) ? sce_pkg::S_MEAN
                                                       : sce_pkg::S_IDLE;
            end
            sce_pkg::S_MEAN: begin
                if (div_rsp.done) begin
                    n_state = sce_pkg::S_MEAN_OUT;
                end
            end
            sce_pkg::S_MEAN_OUT: begin
                if (slot_free) begin
                    n_state = sce_pkg::S_IDLE;
                end
            end
            default: n_state = sce_pkg::S_IDLE;
        endcase
    end

    // datapath and output words
    always_comb begin
        n_cc   = r_cc;
        n_held = r_held;
        n_pos  = r_pos;
        n_loss = r_loss;
        n_drop = r_drop;
        n_cnt  = r_cnt;
        n_ra   = issue ? r_ra + 1'b1 : r_ra;
        n_mx   = r_mx;
        n_tl   = r_tl;
        n_sum  = r_sum;
        n_gc   = r_gc;
        n_q    = r_q;
        n_diff = r_diff;
        n_prod = r_prod;
        n_ov   = r_ov && !o_out.ready;
        n_res  = r_res;
        case (r_state)
            sce_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_held = held_in;
                    if (err0 || err1) begin
                        n_ov  = 1'b1;
                        n_res = '{kind: sce_pkg::KIND_ERR, value: '0, cls: '0, last: 1'b1};
                    end
                    if (!vend) begin
                        n_cc   = cnt_in;
                        n_drop = drop1;
                    end else begin
                        n_cc  = '0;
                        n_cnt = cnt_in;
                        n_ra  = '0;
                        if (drop1 || err1) begin
                            // dropped vector still counts toward the batch
                            if (bend) begin
                                n_pos  = '0;
                                n_loss = '0;
                                n_drop = 1'b0;
                            end else begin
                                n_pos  = r_pos + 1'b1;
                                n_drop = 1'b1;
                            end
                        end
                    end
                end
            end
            sce_pkg::S_MAX: begin
                if (r_rv) begin
                    if (r_ri == '0 || $signed(lg_rdata) > r_mx) begin
                        n_mx = lg_rdata;
                    end
                    if ($signed({9'b0, r_ri}) == r_held) begin
                        n_tl = lg_rdata;
                    end
                    if (r_ri == r_cnt - 1'b1) begin
                        n_ra  = '0;
                        n_sum = '0;
                    end
                end
            end
            sce_pkg::S_EXP: begin
                if (r_bv) begin
                    n_sum = r_sum + SW'(e_wdata);
                end
                n_gc = '0;
            end
            sce_pkg::S_LN2: begin
                n_loss = lsum[LW] ? '1 : lsum[LW-1:0];
            end
            sce_pkg::S_GRD_WP: begin
                if (div_rsp.done) begin
                    n_diff = $signed({1'b0, div_rsp.quo[16:0]})
                             - (hit ? 18'sd65536 : 18'sd0);
                end
            end
            sce_pkg::S_GRD_MUL: begin
                n_prod = r_diff * r_ug;
            end
            sce_pkg::S_GRD_WQ: begin
                if (div_rsp.done) begin
                    n_q = div_rsp.quo;
                end
            end
            sce_pkg::S_GRD_OUT: begin
                if (slot_free) begin
                    n_ov  = 1'b1;
                    n_res = '{kind: sce_pkg::KIND_GRAD,
                              value: neg ? -r_q[31:0] : r_q[31:0],
                              cls: 6'(r_gc),
                              last: (r_gc == r_cnt - 1'b1)};
                    n_gc  = r_gc + 1'b1;
                end
            end
            sce_pkg::S_BEND: begin
                if (!(bend && !r_mode && !r_drop)) begin
                    if (bend) begin
                        n_pos  = '0;
                        n_loss = '0;
                        n_drop = 1'b0;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            sce_pkg::S_MEAN: begin
                if (div_rsp.done) begin
                    n_q = div_rsp.quo;
                end
            end
            sce_pkg::S_MEAN_OUT: begin
                if (slot_free) begin
                    n_ov   = 1'b1;
                    n_res  = '{kind: sce_pkg::KIND_LOSS,
                               value: (r_q > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                                : r_q[31:0],
                               cls: '0, last: 1'b1};
                    n_pos  = '0;
                    n_loss = '0;
                    n_drop = 1'b0;
                end
            end
            default: begin
                n_ov = r_ov && !o_out.ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sce_pkg::S_IDLE;
            r_mode  <= 1'b0;
            r_ncls  <= CW'(10);
            r_npos  <= PW'(1);
            r_ug    <= 16'sd256;
            r_cc    <= '0;
            r_held  <= '0;
            r_pos   <= '0;
            r_loss  <= '0;
            r_drop  <= 1'b0;
            r_cnt   <= CW'(1);
            r_ra    <= '0;
            r_rv    <= 1'b0;
            r_av    <= 1'b0;
            r_bv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    sce_pkg::REG_MODE:  r_mode <= i_cfg.data[0];
                    sce_pkg::REG_NCLS:  r_ncls <= i_cfg.data[CW-1:0];
                    sce_pkg::REG_NPOS:  r_npos <= i_cfg.data;
                    sce_pkg::REG_UGRAD: r_ug   <= i_cfg.data[15:0];
                    default: begin
                        r_mode <= r_mode;
                    end
                endcase
            end
            r_cc   <= n_cc;
            r_held <= n_held;
            r_pos  <= n_pos;
            r_loss <= n_loss;
            r_drop <= n_drop;
            r_cnt  <= n_cnt;
            r_ra   <= n_ra;
            r_rv   <= issue;
            r_av   <= r_rv && (r_state == sce_pkg::S_EXP);
            r_bv   <= r_av;
            r_ov   <= n_ov;
        end
        r_ri   <= r_ra;
        r_mx   <= n_mx;
        r_tl   <= n_tl;
        r_ai   <= r_ri;
        r_am1  <= am1;
        r_af   <= xd[3:0];
        r_bi   <= r_ai;
        r_bm2  <= bm2;
        r_sum  <= n_sum;
        r_lnp  <= n_lnp;
        r_lnb  <= n_lnb;
        r_gc   <= n_gc;
        r_q    <= n_q;
        r_diff <= n_diff;
        r_prod <= n_prod;
        r_res  <= n_res;
    end

    assign i_in.ready        = (r_state == sce_pkg::S_IDLE) && slot_free;
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_ov;
    assign o_out.result_kind = r_res.kind;
    assign o_out.value       = r_res.value;
    assign o_out.class_index = r_res.cls;
    assign o_out.last        = r_res.last;

    // an error word always ends the words of its item
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_res.kind == sce_pkg::KIND_ERR) |-> r_res.last)
        else $error("error word without last");

    // the exp sum always includes exp(0) of the maximum
    a_sum_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sce_pkg::S_LN1) |-> (r_sum >= SW'(65536)))
        else $error("exp sum below one");

    // divider is never restarted while running
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // vector length stays within the ram
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sce_pkg::S_IDLE) |-> (r_cnt >= CW'(1) && r_cnt <= MAXC))
        else $error("vector length out of range");
endmodule
